// ----- hw/rtl/rth_pkg.sv -----
// rth_pkg: shared types and constants for the rgb to hsv converter
// no dependencies

package rth_pkg;

   localparam int CHANNEL_BITS    = 8;
   localparam int FRACTION_BITS   = 16;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = (FRACTION_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [FRACTION_BITS-1:0] hue_turn;
      logic [FRACTION_BITS-1:0] saturation_level;
      logic [CHANNEL_BITS-1:0]  brightness;
   } rsp_type;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

endpackage

// ----- hw/rtl/rgb_to_hsv.sv -----
// rgb_to_hsv: hexcone rgb to hsv conversion, one pixel per clock while rsp_ready holds
// stages are a min/max stage, a hue setup stage and DIV_STAGES divider stages, each of
// two restoring divider bit steps; throughput one request per cycle while rsp_ready holds
// reset clears all stage valid bits synchronously; data registers are not reset
// depends on rth_pkg

module rgb_to_hsv (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rth_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rth_pkg::rsp_type rsp_data
);

   import rth_pkg::*;

   localparam int C = CHANNEL_BITS;
   localparam int F = FRACTION_BITS;

   typedef struct packed {
      logic [C-1:0] bright;
      logic [C-1:0] delta;
      sector_type   sector;
      logic [C:0]   diff;
   } pre_type;

   typedef struct packed {
      logic [C-1:0] bright;
      logic         zero;
      logic [C+2:0] hue_rem;
      logic [C+2:0] hue_div;
      logic [F-1:0] hue_q;
      logic [C-1:0] sat_rem;
      logic [F-1:0] sat_low;
      logic [F-1:0] sat_q;
   } div_type;

   function automatic logic [C+3:0] hue_step(input logic [C+2:0] rem, input logic [C+2:0] dv);
      logic [C+3:0] shifted;
      logic [C+3:0] diff;
      shifted = {rem, 1'b0};
      diff    = shifted - {1'b0, dv};
      if (shifted >= {1'b0, dv}) begin
         return {1'b1, diff[C+2:0]};
      end
      return {1'b0, shifted[C+2:0]};
   endfunction

   function automatic logic [C:0] sat_step(input logic [C-1:0] rem, input logic [C-1:0] dv,
                                           input logic nb);
      logic [C:0] shifted;
      logic [C:0] diff;
      shifted = {rem, nb};
      diff    = shifted - {1'b0, dv};
      if (shifted >= {1'b0, dv}) begin
         return {1'b1, diff[C-1:0]};
      end
      return {1'b0, shifted[C-1:0]};
   endfunction

   // stage 0: max, min, sector, channel difference
   logic    pre_valid_ff;
   pre_type pre_ff;
   pre_type pre_in;
   logic    pre_adv;

   logic          div_valid_ff [0:DIV_STAGES];
   div_type       div_ff       [0:DIV_STAGES];
   div_type       div_in       [0:DIV_STAGES];
   logic          div_adv      [0:DIV_STAGES];

   always_comb begin
      logic [C-1:0] maxv;
      logic [C-1:0] minv;
      maxv = req_data.red;
      minv = req_data.red;
      if (req_data.green > maxv) maxv = req_data.green;
      if (req_data.blue > maxv)  maxv = req_data.blue;
      if (req_data.green < minv) minv = req_data.green;
      if (req_data.blue < minv)  minv = req_data.blue;
      pre_in.bright = maxv;
      pre_in.delta  = maxv - minv;
      if (req_data.red >= req_data.green && req_data.red >= req_data.blue) begin
         pre_in.sector = SECTOR_RED;
         pre_in.diff   = {1'b0, req_data.green} - {1'b0, req_data.blue};
      end else if (req_data.green >= req_data.blue) begin
         pre_in.sector = SECTOR_GREEN;
         pre_in.diff   = {1'b0, req_data.blue} - {1'b0, req_data.red};
      end else begin
         pre_in.sector = SECTOR_BLUE;
         pre_in.diff   = {1'b0, req_data.red} - {1'b0, req_data.green};
      end
   end

   // stage 1: wrapped hue numerator, divisors, saturation dividend
   always_comb begin
      logic signed [C+3:0] base;
      logic signed [C+3:0] num_raw;
      logic        [C+2:0] turn;
      base = '0;
      case (pre_ff.sector)
         SECTOR_RED:   base = '0;
         SECTOR_GREEN: base = $signed((C+4)'({pre_ff.delta, 1'b0}));
         SECTOR_BLUE:  base = $signed((C+4)'({pre_ff.delta, 2'b00}));
         default:      base = '0;
      endcase
      turn    = (C+3)'({pre_ff.delta, 2'b00}) + (C+3)'({pre_ff.delta, 1'b0});
      num_raw = base + $signed({{3{pre_ff.diff[C]}}, pre_ff.diff});
      if (num_raw[C+3]) begin
         num_raw = num_raw + $signed({1'b0, turn});
      end
      div_in[0].bright  = pre_ff.bright;
      div_in[0].zero    = (pre_ff.delta == '0);
      div_in[0].hue_rem = num_raw[C+2:0];
      div_in[0].hue_div = turn;
      div_in[0].hue_q   = '0;
      div_in[0].sat_rem = (pre_ff.delta == '0) ? '0 : pre_ff.delta - C'(1);
      div_in[0].sat_low = F'(0) - F'(pre_ff.delta);
      div_in[0].sat_q   = '0;
   end

   // divider stages: each retires STEPS_PER_STAGE quotient bits of both divisions
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      always_comb begin
         div_type      cur;
         logic [C+3:0] hs;
         logic [C:0]   ss;
         cur = div_ff[k-1];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if ((k - 1) * STEPS_PER_STAGE + j < F) begin
               hs          = hue_step(cur.hue_rem, cur.hue_div);
               cur.hue_rem = hs[C+2:0];
               cur.hue_q   = {cur.hue_q[F-2:0], hs[C+3]};
               ss          = sat_step(cur.sat_rem, cur.bright, cur.sat_low[F-1]);
               cur.sat_rem = ss[C-1:0];
               cur.sat_low = {cur.sat_low[F-2:0], 1'b0};
               cur.sat_q   = {cur.sat_q[F-2:0], ss[C]};
            end
         end
         div_in[k] = cur;
      end
   end

   // stall chain
   always_comb begin
      div_adv[DIV_STAGES] = !div_valid_ff[DIV_STAGES] || rsp_ready;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         div_adv[k] = !div_valid_ff[k] || div_adv[k+1];
      end
      pre_adv = !pre_valid_ff || div_adv[0];
   end

   assign req_ready = pre_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (pre_adv) begin
         pre_valid_ff <= req_valid;
      end
      if (pre_adv) begin
         pre_ff <= pre_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (div_adv[0]) begin
         div_valid_ff[0] <= pre_valid_ff;
      end
      if (div_adv[0]) begin
         div_ff[0] <= div_in[0];
      end
   end

   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[k] <= 1'b0;
         end else if (div_adv[k]) begin
            div_valid_ff[k] <= div_valid_ff[k-1];
         end
         if (div_adv[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // grey and black pixels force hue and saturation to zero
   assign rsp_valid                 = div_valid_ff[DIV_STAGES];
   assign rsp_data.brightness       = div_ff[DIV_STAGES].bright;
   assign rsp_data.saturation_level = div_ff[DIV_STAGES].zero ? '0 : div_ff[DIV_STAGES].sat_q;
   assign rsp_data.hue_turn         = (div_ff[DIV_STAGES].zero || div_ff[DIV_STAGES].sat_q == '0)
                                      ? '0 : div_ff[DIV_STAGES].hue_q;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> pre_valid_ff)
      else $error("accepted request did not enter the first stage");

   a_delta_bound: assert property (@(posedge clock) disable iff (reset)
      pre_valid_ff |-> pre_ff.delta <= pre_ff.bright)
      else $error("channel spread exceeds the largest channel");

   a_hue_below_turn: assert property (@(posedge clock) disable iff (reset)
      div_valid_ff[0] && !div_ff[0].zero |-> div_ff[0].hue_rem < div_ff[0].hue_div)
      else $error("hue numerator not wrapped into one turn");

   a_grey_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturation_level == '0 |-> rsp_data.hue_turn == '0)
      else $error("hue nonzero on an unsaturated pixel");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      div_valid_ff[0] && !div_adv[0] |=> div_valid_ff[0] && $stable(div_ff[0]))
      else $error("stalled stage lost or changed its request");

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench for the rgb_to_hsv pixel converter
// drives rgb requests in bursts against a stalling result side and checks every hsv result
// depends on rth_pkg and rgb_to_hsv

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rth_pkg::*;

   localparam int RANDOM_PIXELS = 630;
   localparam int DRAIN_CYCLES  = 2 + DIV_STAGES + 8;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_AFTER    = 200;

   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_SPARSE,
      STALL_TOGGLE,
      STALL_HOLD
   } stall_mode_type;

   class hsv_scoreboard;
      rsp_type expected_hsv[$];
      int      pixels_seen;
      int      results_checked;
      int      mismatches;

      function rsp_type convert_pixel(req_type px);
         sector_type              sector;
         logic [CHANNEL_BITS-1:0] top;
         logic [CHANNEL_BITS-1:0] bottom;
         longint                  spread;
         longint                  turn;
         longint                  num;
         rsp_type                 hsv;
         top = px.red;
         if (px.green > top) top = px.green;
         if (px.blue > top) top = px.blue;
         bottom = px.red;
         if (px.green < bottom) bottom = px.green;
         if (px.blue < bottom) bottom = px.blue;
         spread = longint'(top) - longint'(bottom);
         hsv = '0;
         hsv.brightness = top;
         if (top != 0) begin
            hsv.saturation_level =
               FRACTION_BITS'((spread * ((longint'(1) << FRACTION_BITS) - 1)) / longint'(top));
         end
         if (hsv.saturation_level != 0 && spread != 0) begin
            if (px.red == top) sector = SECTOR_RED;
            else if (px.green == top) sector = SECTOR_GREEN;
            else sector = SECTOR_BLUE;
            case (sector)
               SECTOR_RED: begin
                  num = longint'(px.green) - longint'(px.blue);
               end
               SECTOR_GREEN: begin
                  num = 2 * spread + longint'(px.blue) - longint'(px.red);
               end
               default: begin
                  num = 4 * spread + longint'(px.red) - longint'(px.green);
               end
            endcase
            turn = 6 * spread;
            if (num < 0) num += turn;
            hsv.hue_turn = FRACTION_BITS'((num << FRACTION_BITS) / turn);
         end
         return hsv;
      endfunction

      function void note_pixel(req_type px);
         expected_hsv.push_back(convert_pixel(px));
         pixels_seen++;
      endfunction

      function void check_hsv(rsp_type got);
         rsp_type want;
         if (expected_hsv.size() == 0) begin
            $error("result with no request pending: hue %0d sat %0d value %0d",
                   got.hue_turn, got.saturation_level, got.brightness);
            mismatches++;
            return;
         end
         want = expected_hsv.pop_front();
         results_checked++;
         if (got.hue_turn !== want.hue_turn) begin
            $error("hue_turn mismatch: expected %0d, got %0d", want.hue_turn, got.hue_turn);
            mismatches++;
         end
         if (got.saturation_level !== want.saturation_level) begin
            $error("saturation_level mismatch: expected %0d, got %0d",
                   want.saturation_level, got.saturation_level);
            mismatches++;
         end
         if (got.brightness !== want.brightness) begin
            $error("brightness mismatch: expected %0d, got %0d",
                   want.brightness, got.brightness);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_hsv.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   hsv_scoreboard sb = new();
   int            idle_cycles;
   int            directed_count;

   rgb_to_hsv u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_pixel(req_data);
         if (rsp_valid && rsp_ready) sb.check_hsv(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("[rgb_to_hsv] ERROR");
            $finish;
         end
      end
   end

   // result side stall pattern, with one long hold-off once traffic is flowing
   initial begin
      stall_mode_type mode;
      int unsigned    span;
      bit             held;
      rsp_ready = 1'b0;
      held = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(10, 60);
         if (!held && sb.results_checked >= HOLD_AFTER) begin
            held = 1'b1;
            mode = STALL_HOLD;
            span = $urandom_range(150, 250);
         end
         repeat (span) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:   rsp_ready <= 1'b1;
               STALL_HALF:   rsp_ready <= ($urandom_range(0, 1) == 1);
               STALL_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               STALL_TOGGLE: rsp_ready <= !rsp_ready;
               default:      rsp_ready <= 1'b0;
            endcase
         end
      end
   end

   function automatic req_type pixel(int r, int g, int b);
      req_type px;
      px.red   = CHANNEL_BITS'(r);
      px.green = CHANNEL_BITS'(g);
      px.blue  = CHANNEL_BITS'(b);
      return px;
   endfunction

   function automatic req_type random_pixel();
      logic [CHANNEL_BITS-1:0] ch [3];
      logic [CHANNEL_BITS-1:0] peak;
      int unsigned             kind;
      int unsigned             i;
      kind = $urandom_range(0, 9);
      peak = CHANNEL_BITS'($urandom);
      for (int n = 0; n < 3; n++) ch[n] = CHANNEL_BITS'($urandom);
      case (kind)
         5: begin
            for (int n = 0; n < 3; n++) ch[n] = peak;
         end
         6: begin
            i = $urandom_range(0, 2);
            ch[i] = peak;
            ch[(i + 1) % 3] = peak;
            ch[(i + 2) % 3] = CHANNEL_BITS'($urandom_range(0, peak));
         end
         7: begin
            for (int n = 0; n < 3; n++) ch[n] = CHANNEL_BITS'($urandom_range(0, 3));
         end
         8: begin
            for (int n = 0; n < 3; n++) begin
               case ($urandom_range(0, 2))
                  0: ch[n] = '0;
                  1: ch[n] = '1;
                  default: ;
               endcase
            end
         end
         9: begin
            for (int n = 0; n < 3; n++) ch[n] = CHANNEL_BITS'(peak + $urandom_range(0, 4));
         end
         default: ;
      endcase
      return pixel(ch[0], ch[1], ch[2]);
   endfunction

   task automatic send_pixel(input req_type px);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      req_type     directed [$];
      int unsigned burst;
      int unsigned gap;
      int          sent;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // black, grey, primaries, ties, hue wrap, tiny and bit patterns
      directed = '{pixel(0, 0, 0), pixel(255, 255, 255), pixel(128, 128, 128),
                   pixel(1, 1, 1), pixel(255, 0, 0), pixel(0, 255, 0), pixel(0, 0, 255),
                   pixel(255, 255, 0), pixel(0, 255, 255), pixel(255, 0, 255),
                   pixel(200, 10, 50), pixel(255, 0, 1), pixel(10, 200, 50),
                   pixel(10, 50, 200), pixel(1, 0, 0), pixel(0, 1, 0), pixel(0, 0, 1),
                   pixel(255, 254, 254), pixel(255, 255, 254), pixel('h55, 'hAA, 'h0F),
                   pixel('hAA, 'h55, 'hF0), pixel(2, 1, 0)};
      directed_count = directed.size();
      foreach (directed[n]) send_pixel(directed[n]);

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         burst = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         for (int n = 0; n < burst && sent < RANDOM_PIXELS; n++) begin
            send_pixel(random_pixel());
            sent++;
         end
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d pixels converted (%0d directed), %0d results checked, %0d mismatches",
               sb.pixels_seen, directed_count, sb.results_checked, sb.mismatches);
      $display("covered black, grey, ties, hue wrap and extremes, then random bursts %s",
               "against a stalling result side with one long hold-off");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[rgb_to_hsv] OK");
      end else begin
         $display("[rgb_to_hsv] ERROR");
      end
      $finish;
   end

endmodule
